>>> hdl/assert_macros.svh
// assertion macros shared by the rpn evaluator modules
// expects i_clk and i_rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define RPN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define RPN_NEVER(lbl, cond, msg) \
    `RPN_ASSERT(lbl, !(cond), msg)

`endif

>>> hdl/rpn_pkg.sv
// shared types, symbol codes and decode for the postfix evaluator
// no dependencies
package rpn_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ENTRIES_W = 5;

    localparam logic [7:0] SYM_DIGIT_LO = 8'd48;
    localparam logic [7:0] SYM_DIGIT_HI = 8'd57;
    localparam logic [7:0] SYM_ADD      = 8'h2B;
    localparam logic [7:0] SYM_SUB      = 8'h2D;
    localparam logic [7:0] SYM_MUL      = 8'h2A;
    localparam logic [7:0] SYM_DIV      = 8'h2F;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

    function automatic t_op decode_symbol(input logic [7:0] sym);
        t_op op;
        priority if (sym >= SYM_DIGIT_LO && sym <= SYM_DIGIT_HI) begin
            op = OP_PUSH;
        end else if (sym == SYM_ADD) begin
            op = OP_ADD;
        end else if (sym == SYM_SUB) begin
            op = OP_SUB;
        end else if (sym == SYM_MUL) begin
            op = OP_MUL;
        end else if (sym == SYM_DIV) begin
            op = OP_DIV;
        end else begin
            op = OP_NONE;
        end
        return op;
    endfunction

endpackage

>>> hdl/rpn_stk_mem.sv
// operand stack storage: one write port, one registered read port
// uses rpn_pkg for the data width
module rpn_stk_mem import rpn_pkg::*; #(
    parameter int unsigned DEPTH = 2,
    parameter int unsigned AW    = 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rpn_div.sv
// signed 32-bit divider, restoring, one quotient bit per cycle
// uses rpn_pkg and assert_macros.svh; divisor must be nonzero
`include "assert_macros.svh"

module rpn_div import rpn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int unsigned STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic              r_neg;
    logic [DATA_W-1:0] r_den;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;

    logic [DATA_W:0]   w_rem_sh;
    logic [DATA_W:0]   w_diff;
    logic              w_fit;
    logic [DATA_W-1:0] n_rem;
    logic [DATA_W-1:0] n_quo;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[DATA_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_den};
        w_fit    = !w_diff[DATA_W];
        n_rem    = w_fit ? w_diff[DATA_W-1:0] : w_rem_sh[DATA_W-1:0];
        n_quo    = {r_quo[DATA_W-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[DATA_W-1] ^ i_req.divisor[DATA_W-1];
            r_den <= i_req.divisor[DATA_W-1] ? (DATA_W'(0) - i_req.divisor) : i_req.divisor;
            r_quo <= i_req.dividend[DATA_W-1] ? (DATA_W'(0) - i_req.dividend)
                                              : i_req.dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    always_comb begin
        o_rsp.busy     = r_busy;
        o_rsp.done     = r_done;
        o_rsp.quotient = r_neg ? (DATA_W'(0) - r_quo) : r_quo;
    end

    `RPN_NEVER(a_div_restart, i_req.start && (r_busy || r_done), "divider restarted while active")
    `RPN_NEVER(a_div_zero, i_req.start && (i_req.divisor == '0), "divider started with zero divisor")
    `RPN_NEVER(a_div_done_busy, r_done && r_busy, "divider done while still busy")

endmodule

>>> hdl/postfix_expression_evaluator.sv
// postfix evaluator top: control sequencer, stack top register, alu, result register
// uses rpn_pkg, rpn_stk_mem, rpn_div and assert_macros.svh
//
//   channel   handshake                  payload
//   input     i_in_valid / o_in_ready    i_symbol, i_last
//   output    o_out_valid / i_out_ready  o_value, o_entries_left, o_underflow,
//                                        o_overflow, o_divide_by_zero
//
// digits and ignored bytes end in the idle state, + - * go to a read state (stack
// read of the second entry), / with a nonzero divisor then the bit-serial divider
// stack top lives in a register and in the stack memory, the entries below in memory
// synchronous active-low reset clears count, flags, sequencer and result valid
// an item marked last waits at the input while an earlier result is not taken
`include "assert_macros.svh"

module postfix_expression_evaluator import rpn_pkg::*; #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_symbol,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_value,
    output logic [ENTRIES_W-1:0] o_entries_left,
    output logic                 o_underflow,
    output logic                 o_overflow,
    output logic                 o_divide_by_zero
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] TWO_COUNT  = CW'(2);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_last, n_last;
    logic   r_sec_ok, n_sec_ok;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_W-1:0] r_top, n_top;
    logic [DATA_W-1:0] r_opa, n_opa;
    logic r_under, n_under;
    logic r_over, n_over;
    logic r_divz, n_divz;

    logic                 r_out_valid, n_out_valid;
    logic [DATA_W-1:0]    r_out_value, n_out_value;
    logic [ENTRIES_W-1:0] r_out_entries, n_out_entries;
    logic r_out_under, n_out_under;
    logic r_out_over, n_out_over;
    logic r_out_divz, n_out_divz;

    logic              w_in_acc;
    t_op               w_op;
    logic              w_arith;
    logic              w_fin;
    logic [DATA_W-1:0] w_sec;
    logic [DATA_W-1:0] w_res;
    logic              w_commit;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    t_div_req div_req;
    t_div_rsp div_rsp;

    rpn_stk_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stk_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready || !i_last);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_op       = decode_symbol(i_symbol);
    assign w_arith    = (w_op == OP_ADD) || (w_op == OP_SUB) ||
                        (w_op == OP_MUL) || (w_op == OP_DIV);
    assign w_sec      = r_sec_ok ? mem_rdata : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_arith) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_op == OP_DIV && r_opa != '0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and control outputs
    always_comb begin
        n_op          = r_op;
        n_last        = r_last;
        n_sec_ok      = r_sec_ok;
        n_count       = r_count;
        n_top         = r_top;
        n_opa         = r_opa;
        n_under       = r_under;
        n_over        = r_over;
        n_divz        = r_divz;
        n_out_valid   = r_out_valid;
        n_out_value   = r_out_value;
        n_out_entries = r_out_entries;
        n_out_under   = r_out_under;
        n_out_over    = r_out_over;
        n_out_divz    = r_out_divz;
        mem_we        = 1'b0;
        mem_waddr     = AW'(r_count - 1'b1);
        mem_wdata     = '0;
        mem_raddr     = AW'(r_count - TWO_COUNT);
        div_req.start    = 1'b0;
        div_req.dividend = w_sec;
        div_req.divisor  = r_opa;
        w_fin         = 1'b0;
        w_commit      = 1'b0;
        w_res         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op   = w_op;
                    n_last = i_last;
                    if (w_op == OP_PUSH) begin
                        if (r_count == FULL_COUNT) begin
                            n_over = 1'b1;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(r_count);
                            mem_wdata = DATA_W'(i_symbol - SYM_DIGIT_LO);
                            n_top     = DATA_W'(i_symbol - SYM_DIGIT_LO);
                            n_count   = r_count + 1'b1;
                        end
                        w_fin = i_last;
                    end else if (w_arith) begin
                        n_opa    = (r_count != '0) ? r_top : '0;
                        n_sec_ok = (r_count >= TWO_COUNT);
                        if (r_count < TWO_COUNT) begin
                            n_under = 1'b1;
                            n_count = CW'(1);
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end else begin
                        w_fin = i_last;
                    end
                end
            end
            S_READ: begin
                unique case (r_op)
                    OP_ADD: begin
                        w_res    = w_sec + r_opa;
                        w_commit = 1'b1;
                    end
                    OP_SUB: begin
                        w_res    = w_sec - r_opa;
                        w_commit = 1'b1;
                    end
                    OP_MUL: begin
                        w_res    = w_sec * r_opa;
                        w_commit = 1'b1;
                    end
                    OP_DIV: begin
                        if (r_opa == '0) begin
                            n_divz   = 1'b1;
                            w_commit = 1'b1;
                        end else begin
                            div_req.start = 1'b1;
                        end
                    end
                    default: begin
                        w_commit = 1'b1;
                    end
                endcase
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    w_res    = div_rsp.quotient;
                    w_commit = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (w_commit) begin
            mem_we    = 1'b1;
            mem_wdata = w_res;
            n_top     = w_res;
            w_fin     = r_last;
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_fin) begin
            n_out_valid   = 1'b1;
            n_out_value   = (n_count == '0) ? '0 : n_top;
            n_out_entries = ENTRIES_W'(n_count);
            n_out_under   = n_under;
            n_out_over    = n_over;
            n_out_divz    = n_divz;
            n_count       = '0;
            n_under       = 1'b0;
            n_over        = 1'b0;
            n_divz        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_NONE;
            r_last      <= 1'b0;
            r_sec_ok    <= 1'b0;
            r_count     <= '0;
            r_under     <= 1'b0;
            r_over      <= 1'b0;
            r_divz      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_last      <= n_last;
            r_sec_ok    <= n_sec_ok;
            r_count     <= n_count;
            r_under     <= n_under;
            r_over      <= n_over;
            r_divz      <= n_divz;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top         <= n_top;
        r_opa         <= n_opa;
        r_out_value   <= n_out_value;
        r_out_entries <= n_out_entries;
        r_out_under   <= n_out_under;
        r_out_over    <= n_out_over;
        r_out_divz    <= n_out_divz;
    end

    assign o_out_valid      = r_out_valid;
    assign o_value          = r_out_value;
    assign o_entries_left   = r_out_entries;
    assign o_underflow      = r_out_under;
    assign o_overflow       = r_out_over;
    assign o_divide_by_zero = r_out_divz;

    `RPN_ASSERT(a_count_bound, r_count <= FULL_COUNT, "stack count above depth")
    `RPN_ASSERT(a_out_free, w_fin |-> (!r_out_valid || i_out_ready), "result overwrites pending item")
    `RPN_ASSERT(a_div_track, (r_state == S_DIV) |-> (div_rsp.busy || div_rsp.done), "divider lost")
    `RPN_ASSERT(a_op_count, (r_state == S_READ) |-> (r_count != '0), "operator without result slot")

endmodule

>>> sim/tb.sv
// testbench for postfix_expression_evaluator: random and directed postfix expressions
// checked against an in-bench stack evaluator; depends on rpn_pkg and the evaluator rtl
`timescale 1ns / 1ps

module tb;
    import rpn_pkg::*;

    localparam int STK_DEPTH    = 16;
    localparam int RANDOM_ITEMS = 1850;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [7:0] sym;
        logic       last;
    } t_sym_item;

    typedef struct {
        logic [31:0]          value;
        logic [ENTRIES_W-1:0] entries;
        logic                 under;
        logic                 over;
        logic                 divz;
    } t_eval_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] in_symbol = 8'd0;
    logic in_last = 1'b0;
    logic out_ready = 1'b0;

    logic                        o_in_ready;
    logic                        o_out_valid;
    logic signed [31:0]          o_value;
    logic [ENTRIES_W-1:0]        o_entries_left;
    logic                        o_underflow;
    logic                        o_overflow;
    logic                        o_divide_by_zero;

    postfix_expression_evaluator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_symbol         (in_symbol),
        .i_last           (in_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_value          (o_value),
        .o_entries_left   (o_entries_left),
        .o_underflow      (o_underflow),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

    always #5 i_clk = ~i_clk;

    // evaluator state mirrored in the bench
    logic [31:0] rpn_stack [STK_DEPTH];
    int          rpn_count;
    logic        flag_under, flag_over, flag_divz;

    t_sym_item    sym_q[$];
    logic [7:0]   expr_buf[$];
    t_eval_result expected_results[$];

    int n_errors, n_sent, n_results, n_active, n_exprs;
    int n_seen_under, n_seen_over, n_seen_divz;
    int tx_gap, rx_stall, hold_left;
    bit tx_calm, rx_calm, hold_done, hold_on;

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 63) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [31:0] pop_operand();
        if (rpn_count == 0) begin
            flag_under = 1'b1;
            return 32'd0;
        end
        rpn_count--;
        return rpn_stack[rpn_count];
    endfunction

    function automatic void push_operand(input logic [31:0] v);
        if (rpn_count >= STK_DEPTH) begin
            flag_over = 1'b1;
        end else begin
            rpn_stack[rpn_count] = v;
            rpn_count++;
        end
    endfunction

    // quotient truncated toward zero, most negative / -1 wraps
    function automatic logic [31:0] div_trunc(input logic [31:0] num, input logic [31:0] den);
        logic [31:0] nm, dm, q;
        nm = num[31] ? -num : num;
        dm = den[31] ? -den : den;
        q  = nm / dm;
        return (num[31] != den[31]) ? -q : q;
    endfunction

    task automatic apply_symbol(input logic [7:0] sym, input logic lst);
        logic [31:0]  top, sec, res;
        t_eval_result r;
        if (sym >= SYM_DIGIT_LO && sym <= SYM_DIGIT_HI) begin
            push_operand(32'(sym - SYM_DIGIT_LO));
        end else if (sym == SYM_ADD || sym == SYM_SUB || sym == SYM_MUL || sym == SYM_DIV) begin
            top = pop_operand();
            sec = pop_operand();
            case (sym)
                SYM_ADD: res = sec + top;
                SYM_SUB: res = sec - top;
                SYM_MUL: res = sec * top;
                default: begin
                    if (top == 32'd0) begin
                        flag_divz = 1'b1;
                        res = 32'd0;
                    end else begin
                        res = div_trunc(sec, top);
                    end
                end
            endcase
            push_operand(res);
        end
        if (lst) begin
            r.value   = (rpn_count == 0) ? 32'd0 : rpn_stack[rpn_count - 1];
            r.entries = ENTRIES_W'(rpn_count);
            r.under   = flag_under;
            r.over    = flag_over;
            r.divz    = flag_divz;
            expected_results.push_back(r);
            n_seen_under += flag_under;
            n_seen_over  += flag_over;
            n_seen_divz  += flag_divz;
            rpn_count  = 0;
            flag_under = 1'b0;
            flag_over  = 1'b0;
            flag_divz  = 1'b0;
        end
    endtask

    task automatic check_result(input t_eval_result want);
        if (o_value !== want.value) begin
            $display("%0t value mismatch: expected %0d, actual %0d",
                     $time, $signed(want.value), o_value);
            n_errors++;
        end
        if (o_entries_left !== want.entries) begin
            $display("%0t entries_left mismatch: expected %0d, actual %0d",
                     $time, want.entries, o_entries_left);
            n_errors++;
        end
        if (o_underflow !== want.under) begin
            $display("%0t underflow mismatch: expected %0b, actual %0b",
                     $time, want.under, o_underflow);
            n_errors++;
        end
        if (o_overflow !== want.over) begin
            $display("%0t overflow mismatch: expected %0b, actual %0b",
                     $time, want.over, o_overflow);
            n_errors++;
        end
        if (o_divide_by_zero !== want.divz) begin
            $display("%0t divide_by_zero mismatch: expected %0b, actual %0b",
                     $time, want.divz, o_divide_by_zero);
            n_errors++;
        end
    endtask

    // item generation
    function automatic logic [7:0] digit(input int d);
        return SYM_DIGIT_LO + 8'(d);
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0:       return SYM_ADD;
            1:       return SYM_SUB;
            2:       return SYM_MUL;
            default: return SYM_DIV;
        endcase
    endfunction

    function automatic void flush_expr();
        t_sym_item it;
        while (expr_buf.size() > 0) begin
            it.sym  = expr_buf.pop_front();
            it.last = (expr_buf.size() == 0);
            if ((it.sym >= SYM_DIGIT_LO && it.sym <= SYM_DIGIT_HI) || it.sym == SYM_ADD ||
                it.sym == SYM_SUB || it.sym == SYM_MUL || it.sym == SYM_DIV)
                n_active++;
            sym_q.push_back(it);
        end
        n_exprs++;
    endfunction

    function automatic void gen_wellformed();
        int operands, depth;
        operands = $urandom_range(1, 10);
        depth    = 0;
        while (operands > 0 || depth > 1) begin
            if (depth >= 2 && (operands == 0 || $urandom_range(0, 1) == 1)) begin
                expr_buf.push_back(rand_op());
                depth--;
            end else begin
                expr_buf.push_back(digit($urandom_range(0, 9)));
                operands--;
                depth++;
            end
            if ($urandom_range(0, 19) == 0) expr_buf.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0) expr_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void gen_broken();
        int n;
        n = $urandom_range(1, 20);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0, 1:    expr_buf.push_back(digit($urandom_range(0, 9)));
                2, 3:    expr_buf.push_back(rand_op());
                default: expr_buf.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    function automatic void gen_overflow();
        repeat ($urandom_range(16, 20)) expr_buf.push_back(digit($urandom_range(0, 9)));
        repeat ($urandom_range(0, 3)) expr_buf.push_back(rand_op());
    endfunction

    function automatic void gen_wide_chain();
        expr_buf.push_back(digit($urandom_range(1, 9)));
        repeat ($urandom_range(4, 14)) begin
            expr_buf.push_back(digit($urandom_range(1, 9)));
            expr_buf.push_back(($urandom_range(0, 3) == 0) ? rand_op() : SYM_MUL);
        end
    endfunction

    // builds 2^31, which wraps to the most negative value
    function automatic void gen_most_negative();
        repeat (2) begin
            expr_buf.push_back(digit(8));
            expr_buf.push_back(digit(8));
            expr_buf.push_back(SYM_MUL);
            expr_buf.push_back(digit(8));
            expr_buf.push_back(digit(8));
            expr_buf.push_back(SYM_MUL);
            expr_buf.push_back(SYM_MUL);
        end
        expr_buf.push_back(SYM_MUL);
        repeat (2) begin
            expr_buf.push_back(digit(8));
            expr_buf.push_back(SYM_MUL);
        end
        expr_buf.push_back(digit(2));
        expr_buf.push_back(SYM_MUL);
        if ($urandom_range(0, 2) != 0) begin
            expr_buf.push_back(digit(0));
            expr_buf.push_back(digit(1));
            expr_buf.push_back(SYM_SUB);
            expr_buf.push_back(SYM_DIV);
        end else begin
            expr_buf.push_back(digit($urandom_range(0, 9)));
            expr_buf.push_back(rand_op());
        end
    endfunction

    // driver
    always @(posedge i_clk) begin : drv
        t_sym_item nxt;
        logic      take;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = in_valid && o_in_ready;
            if (take) begin
                apply_symbol(in_symbol, in_last);
                n_sent++;
            end
            if (in_valid && !take) begin
                // item still offered
            end else if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end else if (sym_q.size() > 0) begin
                nxt = sym_q.pop_front();
                in_symbol <= nxt.sym;
                in_last   <= nxt.last;
                in_valid  <= 1'b1;
                tx_gap = draw_gap(tx_calm);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // long hold-off so the block backs up into its input
    always @(posedge i_clk) begin : hold
        if (!i_rst_n) begin
            hold_on <= 1'b0;
        end else begin
            if (!hold_done && n_results >= HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
            end
            hold_on <= (hold_left > 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_eval_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual value %0d",
                             $time, o_value);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_result(want);
                end
                n_results++;
                rx_stall = draw_gap(rx_calm);
            end
            if (hold_on) begin
                out_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int kind;
        rpn_count = 0;
        flag_under = 1'b0;
        flag_over = 1'b0;
        flag_divz = 1'b0;

        // directed expressions
        expr_buf.push_back(digit(0));
        flush_expr();
        expr_buf.push_back(digit(9));
        flush_expr();
        expr_buf.push_back(SYM_ADD);
        flush_expr();
        expr_buf.push_back(8'hFF);
        flush_expr();
        expr_buf.push_back(8'h00);
        expr_buf.push_back(digit(7));
        expr_buf.push_back(digit(3));
        expr_buf.push_back(SYM_SUB);
        flush_expr();
        expr_buf.push_back(digit(3));
        expr_buf.push_back(digit(7));
        expr_buf.push_back(SYM_SUB);
        flush_expr();
        expr_buf.push_back(digit(6));
        expr_buf.push_back(digit(7));
        expr_buf.push_back(SYM_MUL);
        flush_expr();
        expr_buf.push_back(digit(0));
        expr_buf.push_back(digit(7));
        expr_buf.push_back(SYM_SUB);
        expr_buf.push_back(digit(2));
        expr_buf.push_back(SYM_DIV);
        flush_expr();
        expr_buf.push_back(digit(5));
        expr_buf.push_back(digit(0));
        expr_buf.push_back(SYM_DIV);
        flush_expr();
        expr_buf.push_back(digit(5));
        expr_buf.push_back(SYM_SUB);
        flush_expr();

        // random expressions
        n_active = 0;
        while (n_active < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 68)      gen_wellformed();
            else if (kind < 80) gen_broken();
            else if (kind < 87) gen_overflow();
            else if (kind < 94) gen_wide_chain();
            else                gen_most_negative();
            flush_expr();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sym_q.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $display("%0t %0d results never arrived", $time, expected_results.size());
            n_errors++;
        end
        $display("tb: %0d symbols in %0d expressions, %0d results compared",
                 n_sent, n_exprs, n_results);
        $display("tb: results flagged underflow %0d, overflow %0d, divide by zero %0d",
                 n_seen_under, n_seen_over, n_seen_divz);
        if (n_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("%0t timeout", $time);
        $display("tb: done, errors");
        $finish;
    end

endmodule
